// File: rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types, widths and constants of the cell balance monitor.
// ----------------------------------------------------------------------------
package cbm_pkg;

    localparam int CHAN_W      = 5;
    localparam int CODE_W      = 12;
    localparam int THR_W       = 16;
    localparam int VALUE_W     = 13;
    localparam int MASK_W      = 24;
    localparam int KIND_W      = 2;
    localparam int CMD_W       = 2;
    localparam int SUM_W       = 15;
    localparam int CORR_W      = 4;
    localparam int TIMEOUT_W   = 8;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int ALU_W       = 16;

    localparam logic [SUM_W-1:0] SUM_MAX = 15'h7FFF;

    localparam int GROUP_SPLIT   = 12;
    localparam int WINDOW_FRAMES = 8;
    localparam int FRAME_W       = $clog2(WINDOW_FRAMES);
    localparam int CELL_SHIFT    = 2;
    localparam int TEMP_SHIFT    = $clog2(WINDOW_FRAMES);

    localparam int DEF_NUM_CELLS = 24;
    localparam int DEF_NUM_TEMPS = 4;

    localparam logic [CORR_W-1:0]    RST_CORR    = 4'd6;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT = 8'd32;
    localparam logic [CFG_W-1:0]     RST_OPEN    = 13'd5000;

    typedef enum logic [CMD_W-1:0] {
        CMD_CELL  = 2'd0,
        CMD_TEMP  = 2'd1,
        CMD_FRAME = 2'd2,
        CMD_REQ   = 2'd3
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_CELL = 2'd0,
        KIND_TEMP = 2'd1,
        KIND_MASK = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_CORR   = 2'd0,
        REG_HIGH_CORR  = 2'd1,
        REG_TIMEOUT    = 2'd2,
        REG_OPEN_LIMIT = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_SAT,
        ALU_GT
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CELL_MUL,
        ST_ACC,
        ST_AVG_CORR,
        ST_AVG_HALF,
        ST_AVG_OPEN,
        ST_AVG_SHUNT,
        ST_TEMP_EMIT,
        ST_MASK_EMIT,
        ST_TIMER
    } state_t;

    typedef struct packed {
        alu_op_t          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W:0] res;
        logic           gt;
    } alu_rsp_t;

endpackage

// File: rtl/cbm_alu.sv
// ----------------------------------------------------------------------------
// cbm_alu
// Shared add, subtract, saturating add and compare unit.
// ----------------------------------------------------------------------------
module cbm_alu
    import cbm_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ALU_W:0] sum;
    logic [ALU_W:0] diff;

    assign sum  = {1'b0, req.a} + {1'b0, req.b};
    assign diff = {1'b0, req.a} - {1'b0, req.b};

    always_comb begin
        rsp.gt = (req.a > req.b);
        case (req.op)
            ALU_ADD: rsp.res = sum;
            ALU_SUB: rsp.res = diff;
            ALU_SAT: rsp.res = (sum > (ALU_W+1)'(SUM_MAX)) ? (ALU_W+1)'(SUM_MAX) : sum;
            ALU_GT:  rsp.res = '0;
            default: rsp.res = '0;
        endcase
    end

endmodule

// File: rtl/cbm_sum_bank.sv
// ----------------------------------------------------------------------------
// cbm_sum_bank
// Per-channel running sums, cells first and temperatures after them.
// ----------------------------------------------------------------------------
module cbm_sum_bank
    import cbm_pkg::*;
#(
    parameter int DEPTH = DEF_NUM_CELLS + DEF_NUM_TEMPS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [AW-1:0]    addr,
    input  logic [SUM_W-1:0] wr_data,
    output logic [SUM_W-1:0] rd_data
);

    logic [SUM_W-1:0] sum_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (wr_en) begin
            sum_reg[addr] <= wr_data;
        end
    end

    assign rd_data = sum_reg[addr];

endmodule

// File: rtl/cell_balance_monitor.sv
// ----------------------------------------------------------------------------
// cell_balance_monitor
// Cell voltage and temperature averaging with passive balancing decision.
//
// Input beats (s_*) carry a cell code, a temperature code, a frame end or a
// balance request. Result beats (m_*) carry cell averages, temperature
// averages and, last in a window, the shunt mask with m_last set.
// One shared ALU under a sequencer does all arithmetic; s_ready is high only
// while the sequencer is idle.
// A balance request is taken in the idle state; a temperature code goes through
// the accumulate step, a cell code through the scale and accumulate steps, and
// a frame end through the timer step. The frame end that closes a window of 8
// frames walks the sums: per cell a correction, half-cell, open-wire and shunt
// step, then one step per temperature, one for the mask and the timer step.
// A result register sits on the output; when the receiver stalls, the walk
// holds on the pending result and resumes once it is taken.
// Reset clears all sums, counters, the threshold, the shunt mask and sets
// the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module cell_balance_monitor
    import cbm_pkg::*;
#(
    parameter int NUM_CELLS = DEF_NUM_CELLS,
    parameter int NUM_TEMPS = DEF_NUM_TEMPS
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CMD_W-1:0]     s_command,
    input  logic [CHAN_W-1:0]    s_channel,
    input  logic [CODE_W-1:0]    s_code,
    input  logic [THR_W-1:0]     s_threshold_mv,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [KIND_W-1:0]    m_kind,
    output logic [CHAN_W-1:0]    m_index,
    output logic [VALUE_W-1:0]   m_value,
    output logic [MASK_W-1:0]    m_shunt_mask,
    output logic                 m_last
);

    localparam int DEPTH = NUM_CELLS + NUM_TEMPS;
    localparam int AW    = $clog2(DEPTH);

    logic [CORR_W-1:0]    low_corr_reg;
    logic [CORR_W-1:0]    high_corr_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [CFG_W-1:0]     open_limit_reg;

    state_t               state_reg, state_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [ALU_W-1:0]     acc_reg, acc_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;
    logic [THR_W-1:0]     threshold_reg, threshold_next;
    logic [TIMEOUT_W-1:0] silence_reg, silence_next;
    logic                 pending_reg, pending_next;
    logic [NUM_CELLS-1:0] shunt_reg, shunt_next;

    logic                 m_valid_reg;
    kind_t                m_kind_reg, m_kind_next;
    logic [CHAN_W-1:0]    m_index_reg, m_index_next;
    logic [VALUE_W-1:0]   m_value_reg, m_value_next;
    logic [MASK_W-1:0]    m_mask_reg, m_mask_next;
    logic                 m_last_reg, m_last_next;
    logic                 emit;
    logic                 out_free;

    alu_req_t             alu_req;
    alu_rsp_t             alu_rsp;

    logic                 sum_wr_en;
    logic [SUM_W-1:0]     sum_wr_data;
    logic [SUM_W-1:0]     sum_rd;

    logic [CHAN_W-1:0]    cell_idx;
    logic [CORR_W-1:0]    corr;
    logic                 half_cell;
    logic [VALUE_W-1:0]   base;
    logic [NUM_CELLS-1:0] cell_sel;

    cbm_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    cbm_sum_bank #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_sum_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (sum_wr_en),
        .addr    (addr_reg),
        .wr_data (sum_wr_data),
        .rd_data (sum_rd)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign cell_idx  = CHAN_W'(addr_reg);
    assign corr      = (cell_idx >= CHAN_W'(GROUP_SPLIT)) ? high_corr_reg : low_corr_reg;
    assign half_cell = (cell_idx == '0) || (cell_idx == CHAN_W'(GROUP_SPLIT));
    assign base      = VALUE_W'(sum_rd >> CELL_SHIFT);
    assign cell_sel  = NUM_CELLS'(1) << addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_corr_reg   <= RST_CORR;
            high_corr_reg  <= RST_CORR;
            timeout_reg    <= RST_TIMEOUT;
            open_limit_reg <= RST_OPEN;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_index))
                REG_LOW_CORR:   low_corr_reg   <= CORR_W'(cfg_data);
                REG_HIGH_CORR:  high_corr_reg  <= CORR_W'(cfg_data);
                REG_TIMEOUT:    timeout_reg    <= TIMEOUT_W'(cfg_data);
                REG_OPEN_LIMIT: open_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            addr_reg      <= '0;
            frame_reg     <= '0;
            threshold_reg <= '0;
            silence_reg   <= '0;
            pending_reg   <= 1'b0;
            shunt_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            frame_reg     <= frame_next;
            threshold_reg <= threshold_next;
            silence_reg   <= silence_next;
            pending_reg   <= pending_next;
            shunt_reg     <= shunt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_kind_reg  <= m_kind_next;
            m_index_reg <= m_index_next;
            m_value_reg <= m_value_next;
            m_mask_reg  <= m_mask_next;
            m_last_reg  <= m_last_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        acc_next       = acc_reg;
        frame_next     = frame_reg;
        threshold_next = threshold_reg;
        silence_next   = silence_reg;
        pending_next   = pending_reg;
        shunt_next     = shunt_reg;
        alu_req        = '{op: ALU_ADD, a: '0, b: '0};
        sum_wr_en      = 1'b0;
        sum_wr_data    = '0;
        emit           = 1'b0;
        m_kind_next    = KIND_CELL;
        m_index_next   = '0;
        m_value_next   = '0;
        m_mask_next    = '0;
        m_last_next    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (cmd_t'(s_command))
                        CMD_CELL: begin
                            if (s_channel < CHAN_W'(NUM_CELLS)) begin
                                addr_next  = AW'(s_channel);
                                acc_next   = ALU_W'(s_code);
                                state_next = ST_CELL_MUL;
                            end
                        end
                        CMD_TEMP: begin
                            if (s_channel < CHAN_W'(NUM_TEMPS)) begin
                                addr_next  = AW'(NUM_CELLS) + AW'(s_channel);
                                acc_next   = ALU_W'(s_code);
                                state_next = ST_ACC;
                            end
                        end
                        CMD_FRAME: begin
                            frame_next = frame_reg + 1'b1;
                            if (frame_reg == FRAME_W'(WINDOW_FRAMES - 1)) begin
                                addr_next  = '0;
                                state_next = ST_AVG_CORR;
                            end else begin
                                state_next = ST_TIMER;
                            end
                        end
                        CMD_REQ: begin
                            threshold_next = s_threshold_mv;
                            pending_next   = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end

            ST_CELL_MUL: begin
                alu_req    = '{op: ALU_ADD, a: acc_reg, b: acc_reg << 1};
                acc_next   = ALU_W'(alu_rsp.res >> CELL_SHIFT);
                state_next = ST_ACC;
            end

            ST_ACC: begin
                alu_req     = '{op: ALU_SAT, a: ALU_W'(sum_rd), b: acc_reg};
                sum_wr_en   = 1'b1;
                sum_wr_data = SUM_W'(alu_rsp.res);
                state_next  = ST_IDLE;
            end

            ST_AVG_CORR: begin
                sum_wr_en = 1'b1;
                alu_req   = '{op: ALU_ADD, a: ALU_W'(base), b: ALU_W'(corr)};
                if (base != '0) begin
                    acc_next = ALU_W'(alu_rsp.res);
                end else begin
                    acc_next = '0;
                end
                state_next = ST_AVG_HALF;
            end

            ST_AVG_HALF: begin
                alu_req = '{op: ALU_SUB, a: acc_reg, b: ALU_W'(corr >> 1)};
                if (half_cell && (acc_reg != '0)) begin
                    acc_next = ALU_W'(alu_rsp.res);
                end
                state_next = ST_AVG_OPEN;
            end

            ST_AVG_OPEN: begin
                alu_req = '{op: ALU_GT, a: acc_reg, b: ALU_W'(open_limit_reg)};
                if (alu_rsp.gt) begin
                    acc_next = '0;
                end
                state_next = ST_AVG_SHUNT;
            end

            ST_AVG_SHUNT: begin
                alu_req = '{op: ALU_GT, a: acc_reg, b: threshold_reg};
                if (out_free) begin
                    emit         = 1'b1;
                    m_kind_next  = KIND_CELL;
                    m_index_next = cell_idx;
                    m_value_next = VALUE_W'(acc_reg);
                    if (alu_rsp.gt && (threshold_reg != '0)) begin
                        shunt_next = shunt_reg | cell_sel;
                    end else begin
                        shunt_next = shunt_reg & ~cell_sel;
                    end
                    if (addr_reg == AW'(NUM_CELLS - 1)) begin
                        addr_next  = AW'(NUM_CELLS);
                        state_next = ST_TEMP_EMIT;
                    end else begin
                        addr_next  = addr_reg + 1'b1;
                        state_next = ST_AVG_CORR;
                    end
                end
            end

            ST_TEMP_EMIT: begin
                if (out_free) begin
                    emit         = 1'b1;
                    sum_wr_en    = 1'b1;
                    m_kind_next  = KIND_TEMP;
                    m_index_next = CHAN_W'(addr_reg - AW'(NUM_CELLS));
                    m_value_next = VALUE_W'(sum_rd >> TEMP_SHIFT);
                    if (addr_reg == AW'(DEPTH - 1)) begin
                        state_next = ST_MASK_EMIT;
                    end else begin
                        addr_next = addr_reg + 1'b1;
                    end
                end
            end

            ST_MASK_EMIT: begin
                if (out_free) begin
                    emit        = 1'b1;
                    m_kind_next = KIND_MASK;
                    m_mask_next = MASK_W'(shunt_reg);
                    m_last_next = 1'b1;
                    state_next  = ST_TIMER;
                end
            end

            ST_TIMER: begin
                alu_req = '{op: ALU_GT, a: ALU_W'(timeout_reg), b: ALU_W'(silence_reg)};
                if (alu_rsp.gt) begin
                    silence_next = silence_reg + 1'b1;
                end else begin
                    threshold_next = '0;
                end
                if (pending_reg) begin
                    pending_next = 1'b0;
                    silence_next = '0;
                end
                state_next = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_index      = m_index_reg;
    assign m_value      = m_value_reg;
    assign m_shunt_mask = m_mask_reg;
    assign m_last       = m_last_reg;

endmodule
